### hw/rtl/modular_arith_unit_macros.svh
// assertion macros shared by the modular arithmetic unit rtl
// no dependencies; included by files that carry concurrent checks
`ifndef MODULAR_ARITH_UNIT_MACROS_SVH
`define MODULAR_ARITH_UNIT_MACROS_SVH

// implication checked in the same cycle
`define MAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mau_pkg.sv
// types and constants of the modular arithmetic unit
// no dependencies; used by the interfaces and all modules
package mau_pkg;

    typedef logic [2:0]  t_cmd;
    typedef logic [29:0] t_res;

    localparam t_cmd CMD_ADD = 3'd0;
    localparam t_cmd CMD_SUB = 3'd1;
    localparam t_cmd CMD_MUL = 3'd2;
    localparam t_cmd CMD_POW = 3'd3;
    localparam t_cmd CMD_INV = 3'd4;
    localparam t_cmd CMD_DIV = 3'd5;

    localparam t_res        P_MOD      = 30'd1000000007;
    localparam logic [31:0] P_MOD_X2   = 32'd2000000014;
    localparam logic [31:0] P_MOD_X3   = 32'd3000000021;
    localparam t_res        FERMAT_EXP = 30'd1000000005;
    // floor(2^60 / p)
    localparam logic [30:0] BARRETT_M  = 31'd1152921496;

    typedef struct packed {
        logic valid;
        logic tag;
    } t_mul_ctl;

endpackage

### hw/rtl/mau_if.sv
// request and response channel interfaces of the modular arithmetic unit
// depends on mau_pkg
interface mau_req_if
    import mau_pkg::*;
();
    logic        valid;
    logic        ready;
    t_cmd        command;
    logic [29:0] operand_a;
    logic [29:0] operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

interface mau_rsp_if
    import mau_pkg::*;
();
    logic valid;
    logic ready;
    t_res result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

### hw/rtl/mau_mulmod.sv
// four-stage pipelined modular multiplier mod 1000000007 with barrett reduction
// depends on mau_pkg and modular_arith_unit_macros.svh
`include "modular_arith_unit_macros.svh"

module mau_mulmod
    import mau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_ctl i_ctl,
    input  t_res     i_a,
    input  t_res     i_b,
    output t_mul_ctl o_ctl,
    output t_res     o_res
);

    t_mul_ctl    r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [59:0] r_prod;
    logic [62:0] r_t;
    logic [31:0] r_xl2, r_xl3, r_qpl;
    t_res        r_res;

    logic [59:0] w_prod;
    logic [62:0] w_t;
    logic [30:0] w_q;
    logic [60:0] w_qp;
    logic [31:0] w_diff, w_d1, w_d2;
    t_res        n_res;

    assign w_prod = 60'(i_a) * 60'(i_b);
    assign w_t    = 63'(r_prod[59:28]) * 63'(BARRETT_M);
    assign w_q    = r_t[62:32];
    assign w_qp   = 61'(w_q) * 61'(P_MOD);
    // true remainder is below 3p, so 32 bits of wrap are exact
    assign w_diff = r_xl3 - r_qpl;
    assign w_d1   = w_diff - 32'(P_MOD);
    assign w_d2   = w_diff - P_MOD_X2;

    always_comb begin
        priority if (w_diff >= P_MOD_X2) begin
            n_res = w_d2[29:0];
        end else if (w_diff >= 32'(P_MOD)) begin
            n_res = w_d1[29:0];
        end else begin
            n_res = w_diff[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_t    <= w_t;
        r_xl2  <= r_prod[31:0];
        r_xl3  <= r_xl2;
        r_qpl  <= w_qp[31:0];
        r_res  <= n_res;
    end

    assign o_ctl = r_ctl4;
    assign o_res = r_res;

    `MAU_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, r_ctl3.valid, w_diff < P_MOD_X3,
        "barrett remainder not below 3p")
    `MAU_ASSERT_NOW(a_res_range, i_clk, i_rst_n, r_ctl4.valid, r_res < P_MOD,
        "multiplier result not reduced")

endmodule

### hw/rtl/modular_arith_unit.sv
// Modular arithmetic unit over the prime 1000000007: one request in, one result out.
// Add and subtract are computed combinationally when the request is taken. Multiply runs
// through the shared 4-stage modular multiplier. Power walks the exponent bits up to the
// highest set bit (at least one bit): square-and-multiply issues two products per
// bit into the multiplier and waits for both. Inverse raises to p-2 (30 bits of p-2) and
// divide multiplies by the divisor's inverse. The unit takes a new request only when the
// previous result has been handed to the output register.
// depends on mau_pkg, mau_if, mau_mulmod and modular_arith_unit_macros.svh
`include "modular_arith_unit_macros.svh"

module modular_arith_unit
    import mau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mau_req_if.sink   i_req,
    mau_rsp_if.source o_rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQA   = 3'd1;
    localparam logic [2:0] S_SQB   = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_FWAIT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    t_res       r_acc, n_acc;
    t_res       r_sq, n_sq;
    t_res       r_exp, n_exp;
    t_res       r_opa, n_opa;
    logic       r_out_valid, n_out_valid;
    t_res       r_out_res, n_out_res;

    t_res        w_a, w_b;
    logic [30:0] w_sum, w_sum_red, w_sub_wrap;
    t_res        w_add, w_sub;
    logic        w_accept;

    t_mul_ctl w_mul_in_ctl, w_mul_out_ctl;
    t_res     w_mul_a, w_mul_b, w_mul_res;

    // operands are below 2p, one conditional subtract reduces them
    assign w_a = (i_req.operand_a >= P_MOD) ? i_req.operand_a - P_MOD : i_req.operand_a;
    assign w_b = (i_req.operand_b >= P_MOD) ? i_req.operand_b - P_MOD : i_req.operand_b;

    assign w_sum      = 31'(w_a) + 31'(w_b);
    assign w_sum_red  = w_sum - 31'(P_MOD);
    assign w_add      = (w_sum >= 31'(P_MOD)) ? w_sum_red[29:0] : w_sum[29:0];
    assign w_sub_wrap = 31'(w_a) + 31'(P_MOD) - 31'(w_b);
    assign w_sub      = (w_a >= w_b) ? w_a - w_b : w_sub_wrap[29:0];

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // multiplier issue: acc*sq, then sq*sq, or the closing acc*opa
    always_comb begin
        w_mul_in_ctl.valid = (r_state == S_SQA) || (r_state == S_SQB) || (r_state == S_FINAL);
        w_mul_in_ctl.tag   = (r_state == S_SQB);
        w_mul_a            = (r_state == S_SQB) ? r_sq : r_acc;
        w_mul_b            = (r_state == S_FINAL) ? r_opa : r_sq;
    end

    mau_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_in_ctl),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_ctl   (w_mul_out_ctl),
        .o_res   (w_mul_res)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_exp       = r_exp;
        n_opa       = r_opa;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_res   = r_out_res;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_req.command;
                    n_acc = 30'd1;
                    n_sq  = w_a;
                    n_opa = w_a;
                    n_exp = FERMAT_EXP;
                    unique case (i_req.command)
                        CMD_ADD: begin
                            n_acc   = w_add;
                            n_state = S_DONE;
                        end
                        CMD_SUB: begin
                            n_acc   = w_sub;
                            n_state = S_DONE;
                        end
                        CMD_MUL: begin
                            n_acc   = w_b;
                            n_state = S_FINAL;
                        end
                        CMD_POW: begin
                            n_exp   = i_req.operand_b;
                            n_state = S_SQA;
                        end
                        CMD_INV: begin
                            n_state = S_SQA;
                        end
                        CMD_DIV: begin
                            n_sq    = w_b;
                            n_state = S_SQA;
                        end
                        default: begin
                            n_acc   = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SQA: begin
                n_state = S_SQB;
            end
            S_SQB: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_mul_out_ctl.valid && !w_mul_out_ctl.tag && r_exp[0]) begin
                    n_acc = w_mul_res;
                end
                // square comes back last, in the cycle after the accumulate product
                if (w_mul_out_ctl.valid && w_mul_out_ctl.tag) begin
                    n_sq  = w_mul_res;
                    n_exp = r_exp >> 1;
                    if (r_exp[29:1] == '0) begin
                        n_state = (r_cmd == CMD_DIV) ? S_FINAL : S_DONE;
                    end else begin
                        n_state = S_SQA;
                    end
                end
            end
            S_FINAL: begin
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                if (w_mul_out_ctl.valid) begin
                    n_acc   = w_mul_res;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_acc     <= n_acc;
        r_sq      <= n_sq;
        r_exp     <= n_exp;
        r_opa     <= n_opa;
        r_out_res <= n_out_res;
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.result = r_out_res;

    `MAU_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_rsp.valid, o_rsp.result < P_MOD,
        "result not a residue")
    `MAU_ASSERT_NOW(a_mul_ret_state, i_clk, i_rst_n, w_mul_out_ctl.valid,
        (r_state == S_WAIT) || (r_state == S_FWAIT), "product returned outside a wait state")
    `MAU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE,
        "request accepted but sequencer stayed idle")

endmodule
